// ----- hdl/mas_pkg.sv -----
// Shared constants, types and helpers for the matrix add/subtract/multiply engine.
package mas_pkg;

    localparam int MAX_DIM    = 8;
    localparam int ELEM_W     = 32;
    localparam int IDX_W      = 3;
    localparam int ADDR_W     = 2 * IDX_W;
    localparam int MEM_DEPTH  = 1 << ADDR_W;
    localparam int DIM_W      = 4;
    localparam int MODE_W     = 2;
    localparam int OP_W       = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 4;

    localparam logic [MODE_W-1:0] MODE_LOAD_A  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_B  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd2;

    localparam logic [OP_W-1:0] OP_ADD = 2'd0;
    localparam logic [OP_W-1:0] OP_SUB = 2'd1;
    localparam logic [OP_W-1:0] OP_MUL = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_A_ROWS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_A_COLS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B_ROWS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_B_COLS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OPERATION = 3'd4;

    localparam logic [DIM_W-1:0] DIM_RESET = 4'd3;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [ELEM_W-1:0] elem_t;
    typedef logic [ADDR_W-1:0] addr_t;

    // Dimensions held as (size - 1) after saturation
    typedef struct packed {
        idx_t            m_last;
        idx_t            n_last;
        idx_t            p_last;
        idx_t            q_last;
        logic [OP_W-1:0] op;
    } cfg_t;

    // Control that travels with each pair of memory reads
    typedef struct packed {
        logic valid;
        logic first;
        logic lastk;
        logic last;
        logic err;
        idx_t row;
        idx_t col;
    } tok_t;

    typedef struct packed {
        logic  we_a;
        logic  we_b;
        addr_t addr;
        elem_t data;
    } wr_t;

    typedef struct packed {
        logic  re;
        addr_t addr_a;
        addr_t addr_b;
    } rd_t;

    // Clamp a dimension register to 1..MAX_DIM and return size - 1
    function automatic idx_t dim_last(logic [DIM_W-1:0] v);
        idx_t r;
        if (v == '0)
            r = '0;
        else if (int'(v) > MAX_DIM)
            r = IDX_W'(MAX_DIM - 1);
        else
            r = IDX_W'(v - DIM_W'(1));
        return r;
    endfunction

endpackage

// ----- hdl/mas_item_if.sv -----
// Request channel: element loads and compute requests.
interface mas_item_if;
    import mas_pkg::*;

    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    idx_t                row_index;
    idx_t                col_index;
    logic signed [ELEM_W-1:0] element_value;

    modport source (output valid, mode, row_index, col_index, element_value, input ready);
    modport sink   (input valid, mode, row_index, col_index, element_value, output ready);
endinterface

// ----- hdl/mas_result_if.sv -----
// Result channel: one matrix element per transfer.
interface mas_result_if;
    import mas_pkg::*;

    logic                valid;
    logic                ready;
    idx_t                out_row;
    idx_t                out_col;
    logic signed [ELEM_W-1:0] out_value;
    logic                last;
    logic                dim_error;

    modport source (output valid, out_row, out_col, out_value, last, dim_error, input ready);
    modport sink   (input valid, out_row, out_col, out_value, last, dim_error, output ready);
endinterface

// ----- hdl/mas_cfg_if.sv -----
// Configuration write channel.
interface mas_cfg_if;
    import mas_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/matrix_add_sub_multiply.sv -----
// Top level of the integer matrix add/subtract/multiply engine.
//
//   channel  role    carries
//   item     sink    mode, row_index, col_index, element_value
//   result   source  out_row, out_col, out_value, last, dim_error
//   cfg      sink    index, data (a_rows, a_cols, b_rows, b_cols, operation)
//
// Loads may arrive back to back.
// A compute request walks the stores through the single read port of each RAM:
// add/subtract issue rows*cols read pairs, multiply rows*cols*inner, through the
// read-data, product and output registers; item ready returns once the last read is issued.
// Reset clears the sequencer, pipeline valids and registers; the stores are not cleared.
// A stalled result freezes the whole read/compute pipeline in place.
module matrix_add_sub_multiply (
    input  logic          clk,
    input  logic          rst_n,
    mas_item_if.sink      item,
    mas_result_if.source  result,
    mas_cfg_if.sink       cfg
);
    import mas_pkg::*;

    cfg_t  cfg_val;
    wr_t   wr;
    rd_t   rd;
    tok_t  tok;
    logic  adv;
    elem_t a_data, b_data;

    mas_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_val (cfg_val)
    );

    mas_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .cfg_val (cfg_val),
        .adv     (adv),
        .wr      (wr),
        .rd      (rd),
        .tok     (tok)
    );

    mas_ram #(.WIDTH(ELEM_W), .DEPTH(MEM_DEPTH)) u_ram_a (
        .clk   (clk),
        .we    (wr.we_a),
        .waddr (wr.addr),
        .wdata (wr.data),
        .re    (rd.re),
        .raddr (rd.addr_a),
        .rdata (a_data)
    );

    mas_ram #(.WIDTH(ELEM_W), .DEPTH(MEM_DEPTH)) u_ram_b (
        .clk   (clk),
        .we    (wr.we_b),
        .waddr (wr.addr),
        .wdata (wr.data),
        .re    (rd.re),
        .raddr (rd.addr_b),
        .rdata (b_data)
    );

    mas_alu u_alu (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_val (cfg_val),
        .tok     (tok),
        .a_data  (a_data),
        .b_data  (b_data),
        .adv     (adv),
        .result  (result)
    );

endmodule

// ----- hdl/mas_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module mas_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/mas_cfg.sv -----
// Configuration register file with dimension clamping.
module mas_cfg (
    input  logic            clk,
    input  logic            rst_n,
    mas_cfg_if.sink         cfg,
    output mas_pkg::cfg_t   cfg_val
);
    import mas_pkg::*;

    logic [DIM_W-1:0] a_rows_reg, a_cols_reg, b_rows_reg, b_cols_reg;
    logic [OP_W-1:0]  op_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_rows_reg <= DIM_RESET;
            a_cols_reg <= DIM_RESET;
            b_rows_reg <= DIM_RESET;
            b_cols_reg <= DIM_RESET;
            op_reg     <= OP_ADD;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_A_ROWS:    a_rows_reg <= cfg.data;
                REG_A_COLS:    a_cols_reg <= cfg.data;
                REG_B_ROWS:    b_rows_reg <= cfg.data;
                REG_B_COLS:    b_cols_reg <= cfg.data;
                REG_OPERATION: op_reg     <= cfg.data[OP_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        cfg_val.m_last = dim_last(a_rows_reg);
        cfg_val.n_last = dim_last(a_cols_reg);
        cfg_val.p_last = dim_last(b_rows_reg);
        cfg_val.q_last = dim_last(b_cols_reg);
        cfg_val.op     = op_reg;
    end

endmodule

// ----- hdl/mas_seq.sv -----
// Request intake and address sequencer that walks the two matrix stores.
module mas_seq (
    input  logic           clk,
    input  logic           rst_n,
    mas_item_if.sink       item,
    input  mas_pkg::cfg_t  cfg_val,
    input  logic           adv,
    output mas_pkg::wr_t   wr,
    output mas_pkg::rd_t   rd,
    output mas_pkg::tok_t  tok
);
    import mas_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    logic [1:0] state_reg, state_next;
    idx_t       i_reg, i_next, j_reg, j_next, k_reg, k_next;
    tok_t       tok_reg, tok_next;
    logic       accept;
    logic       mul;
    idx_t       col_last;
    logic       in_range;

    assign item.ready = (state_reg == ST_IDLE);
    assign accept     = item.valid && item.ready;
    assign mul        = (cfg_val.op == OP_MUL);
    assign col_last   = mul ? cfg_val.q_last : cfg_val.n_last;
    assign in_range   = (int'(item.row_index) < MAX_DIM) && (int'(item.col_index) < MAX_DIM);

    always_comb
    begin
        wr.we_a = accept && (item.mode == MODE_LOAD_A) && in_range;
        wr.we_b = accept && (item.mode == MODE_LOAD_B) && in_range;
        wr.addr = {item.row_index, item.col_index};
        wr.data = item.element_value;
    end

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        tok_next   = '0;
        rd.re      = 1'b0;
        rd.addr_a  = mul ? {i_reg, k_reg} : {i_reg, j_reg};
        rd.addr_b  = mul ? {k_reg, j_reg} : {i_reg, j_reg};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && item.mode == MODE_COMPUTE)
                begin
                    i_next = '0;
                    j_next = '0;
                    k_next = '0;
                    if (cfg_val.op == OP_ADD || cfg_val.op == OP_SUB)
                        state_next = ST_RUN;
                    else if (mul)
                        state_next = (cfg_val.n_last != cfg_val.p_last) ? ST_ERR : ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (adv)
                begin
                    rd.re          = 1'b1;
                    tok_next.valid = 1'b1;
                    tok_next.first = !mul || (k_reg == '0);
                    tok_next.lastk = !mul || (k_reg == cfg_val.n_last);
                    tok_next.last  = tok_next.lastk && (i_reg == cfg_val.m_last)
                                     && (j_reg == col_last);
                    tok_next.err   = 1'b0;
                    tok_next.row   = i_reg;
                    tok_next.col   = j_reg;
                    // advance inner product, then column, then row
                    if (mul && k_reg != cfg_val.n_last)
                        k_next = k_reg + IDX_W'(1);
                    else
                    begin
                        k_next = '0;
                        if (j_reg != col_last)
                            j_next = j_reg + IDX_W'(1);
                        else
                        begin
                            j_next = '0;
                            if (i_reg != cfg_val.m_last)
                                i_next = i_reg + IDX_W'(1);
                            else
                                state_next = ST_IDLE;
                        end
                    end
                end
            end
            ST_ERR:
            begin
                if (adv)
                begin
                    tok_next.valid = 1'b1;
                    tok_next.first = 1'b1;
                    tok_next.lastk = 1'b1;
                    tok_next.last  = 1'b1;
                    tok_next.err   = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            tok_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            // hold the token while the pipeline is stalled, like the read data
            if (adv)
                tok_reg <= tok_next;
        end
    end

    assign tok = tok_reg;

endmodule

// ----- hdl/mas_alu.sv -----
// Arithmetic pipeline: add/subtract/multiply, accumulate, output register.
module mas_alu (
    input  logic           clk,
    input  logic           rst_n,
    input  mas_pkg::cfg_t  cfg_val,
    input  mas_pkg::tok_t  tok,
    input  mas_pkg::elem_t a_data,
    input  mas_pkg::elem_t b_data,
    output logic           adv,
    mas_result_if.source   result
);
    import mas_pkg::*;

    tok_t  t2_reg;
    elem_t prod_reg, prod_next;
    elem_t acc_reg;
    elem_t sum;
    logic  out_valid_reg;
    idx_t  out_row_reg, out_col_reg;
    elem_t out_value_reg;
    logic  out_last_reg, out_err_reg;

    assign adv = !out_valid_reg || result.ready;

    always_comb
    begin
        unique case (cfg_val.op)
            OP_ADD:  prod_next = a_data + b_data;
            OP_SUB:  prod_next = a_data - b_data;
            OP_MUL:  prod_next = a_data * b_data;
            default: prod_next = '0;
        endcase
        if (tok.err)
            prod_next = '0;
    end

    assign sum = (t2_reg.first ? '0 : acc_reg) + prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t2_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            t2_reg        <= tok;
            out_valid_reg <= t2_reg.valid && t2_reg.lastk;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= prod_next;
            if (t2_reg.valid)
            begin
                acc_reg <= sum;
                if (t2_reg.lastk)
                begin
                    out_value_reg <= sum;
                    out_row_reg   <= t2_reg.row;
                    out_col_reg   <= t2_reg.col;
                    out_last_reg  <= t2_reg.last;
                    out_err_reg   <= t2_reg.err;
                end
            end
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.out_row   = out_row_reg;
    assign result.out_col   = out_col_reg;
    assign result.out_value = out_value_reg;
    assign result.last      = out_last_reg;
    assign result.dim_error = out_err_reg;

endmodule
